### rtl/hmqpt_pkg.sv
`timescale 1ns / 1ps

package hmqpt_pkg;

    // The table size must be a power of two: the home slot and the probe
    // wrap both reduce to the low index bits.
    localparam int unsigned TABLE_ENTRIES = 4096;
    localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);

    localparam logic [31:0] EMPTY_KEY   = 32'hFFFF_FFFF;
    localparam logic [31:0] INVALID_PPA = 32'hFFFF_FFFF;

    localparam logic [1:0] FUNC_LOOKUP  = 2'd0;
    localparam logic [1:0] FUNC_PROMOTE = 2'd1;
    localparam logic [1:0] FUNC_CLEAR   = 2'd2;

    localparam logic [2:0] ST_MISS         = 3'd0;
    localparam logic [2:0] ST_HIT          = 3'd1;
    localparam logic [2:0] ST_INSERTED     = 3'd2;
    localparam logic [2:0] ST_OVERWROTE    = 3'd3;
    localparam logic [2:0] ST_NOT_ELIGIBLE = 3'd4;
    localparam logic [2:0] ST_CLEARED      = 3'd5;

    localparam logic CFG_HOT_THRESHOLD = 1'b0;
    localparam logic CFG_MAX_PROBES    = 1'b1;

    typedef logic [IDX_W-1:0] t_idx;

    typedef struct packed {
        logic [31:0] key;
        logic [31:0] ppa;
        logic [31:0] print;
    } t_slot;

endpackage

### rtl/hmqpt_slot_ram.sv
`timescale 1ns / 1ps

module hmqpt_slot_ram (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  hmqpt_pkg::t_idx   i_wr_addr,
    input  hmqpt_pkg::t_slot  i_wr_data,
    input  logic              i_rd_en,
    input  hmqpt_pkg::t_idx   i_rd_addr,
    output hmqpt_pkg::t_slot  o_rd_data
);

    hmqpt_pkg::t_slot r_mem [hmqpt_pkg::TABLE_ENTRIES];
    hmqpt_pkg::t_slot r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/hot_mapping_quadratic_probe_table_core.sv
`timescale 1ns / 1ps

// Hot mapping table with quadratic probing over a 4096-slot single-port-read
// memory. One request is worked at a time. A lookup or promote reads one
// slot per cycle along its probe chain; a request that is rejected or answered
// without probing goes straight to the result, and a clear writes one slot per
// cycle over the whole table. After reset the block empties the table and
// accepts no request until that pass is done; configuration writes are taken
// at any time. A new request is accepted while the previous result still
// waits in the output register.
module hot_mapping_quadratic_probe_table_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_func,
    input  logic [31:0] i_logical_addr,
    input  logic [31:0] i_mapped_ppa,
    input  logic [31:0] i_key_print,
    input  logic [7:0]  i_hit_count,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [31:0] o_found_ppa,
    output logic [31:0] o_found_print
);

    typedef enum logic [3:0] {
        S_CLEAR  = 4'b0001,
        S_IDLE   = 4'b0010,
        S_PROBE  = 4'b0100,
        S_RESULT = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [7:0] r_hot_threshold;
    logic [7:0] r_max_probes;

    hmqpt_pkg::t_idx r_clr_idx, n_clr_idx;
    logic            r_clr_reply, n_clr_reply;

    logic [1:0]      r_func, n_func;
    logic [31:0]     r_addr, n_addr;
    logic [31:0]     r_ppa, n_ppa;
    logic [31:0]     r_print, n_print;
    hmqpt_pkg::t_idx r_idx, n_idx;
    logic [7:0]      r_step, n_step;
    logic [2:0]      r_res_status, n_res_status;
    logic [31:0]     r_res_ppa, n_res_ppa;
    logic [31:0]     r_res_print, n_res_print;

    logic        r_out_valid;
    logic [2:0]  r_out_status;
    logic [31:0] r_out_ppa;
    logic [31:0] r_out_print;

    logic             wr_en;
    hmqpt_pkg::t_idx  wr_addr;
    hmqpt_pkg::t_slot wr_data;
    logic             rd_en;
    hmqpt_pkg::t_idx  rd_addr;
    hmqpt_pkg::t_slot rd_data;

    logic            accept;
    logic            out_free;
    logic [15:0]     step_sq;
    hmqpt_pkg::t_idx next_idx;
    logic            slot_empty;
    logic            slot_match;
    logic            lookup_more;
    logic            promote_more;
    logic            eligible;

    hmqpt_slot_ram u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    assign step_sq      = 16'(r_step) * 16'(r_step);
    assign next_idx     = r_idx + hmqpt_pkg::t_idx'(step_sq);
    assign slot_empty   = (rd_data.key == hmqpt_pkg::EMPTY_KEY);
    assign slot_match   = (rd_data.key == r_addr);
    // Lookup checks step + 1 against the limit before its next probe; promote
    // checks the current step.
    assign lookup_more  = (({1'b0, r_step} + 9'd1) < {1'b0, r_max_probes});
    assign promote_more = (r_step < r_max_probes);
    assign eligible     = (i_logical_addr != hmqpt_pkg::EMPTY_KEY)
                       && (i_mapped_ppa != hmqpt_pkg::INVALID_PPA)
                       && (i_hit_count >= r_hot_threshold);

    always_comb begin
        n_state      = r_state;
        n_clr_idx    = r_clr_idx;
        n_clr_reply  = r_clr_reply;
        n_func       = r_func;
        n_addr       = r_addr;
        n_ppa        = r_ppa;
        n_print      = r_print;
        n_idx        = r_idx;
        n_step       = r_step;
        n_res_status = r_res_status;
        n_res_ppa    = r_res_ppa;
        n_res_print  = r_res_print;
        wr_en        = 1'b0;
        wr_addr      = r_idx;
        wr_data      = '{key: r_addr, ppa: r_ppa, print: r_print};
        rd_en        = 1'b0;
        rd_addr      = next_idx;

        unique case (r_state)
            S_CLEAR: begin
                wr_en     = 1'b1;
                wr_addr   = r_clr_idx;
                wr_data   = '{key: hmqpt_pkg::EMPTY_KEY, ppa: hmqpt_pkg::INVALID_PPA,
                              print: 32'd0};
                n_clr_idx = r_clr_idx + hmqpt_pkg::t_idx'(1);
                if (r_clr_idx == hmqpt_pkg::t_idx'(hmqpt_pkg::TABLE_ENTRIES - 1)) begin
                    n_res_status = hmqpt_pkg::ST_CLEARED;
                    n_res_ppa    = 32'd0;
                    n_res_print  = 32'd0;
                    n_state      = r_clr_reply ? S_RESULT : S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_func       = i_func;
                    n_addr       = i_logical_addr;
                    n_ppa        = i_mapped_ppa;
                    n_print      = i_key_print;
                    n_idx        = i_logical_addr[hmqpt_pkg::IDX_W-1:0];
                    n_step       = 8'd1;
                    n_res_ppa    = 32'd0;
                    n_res_print  = 32'd0;
                    n_res_status = hmqpt_pkg::ST_NOT_ELIGIBLE;
                    rd_addr      = i_logical_addr[hmqpt_pkg::IDX_W-1:0];
                    unique case (i_func)
                        hmqpt_pkg::FUNC_LOOKUP: begin
                            if (i_logical_addr == hmqpt_pkg::EMPTY_KEY
                                || r_max_probes <= 8'd1) begin
                                n_res_status = hmqpt_pkg::ST_MISS;
                                n_state      = S_RESULT;
                            end else begin
                                rd_en   = 1'b1;
                                n_state = S_PROBE;
                            end
                        end
                        hmqpt_pkg::FUNC_PROMOTE: begin
                            if (eligible) begin
                                rd_en   = 1'b1;
                                n_state = S_PROBE;
                            end else begin
                                n_state = S_RESULT;
                            end
                        end
                        hmqpt_pkg::FUNC_CLEAR: begin
                            n_clr_idx   = '0;
                            n_clr_reply = 1'b1;
                            n_state     = S_CLEAR;
                        end
                        default: begin
                            n_state = S_RESULT;
                        end
                    endcase
                end
            end
            S_PROBE: begin
                if (r_func == hmqpt_pkg::FUNC_LOOKUP) begin
                    if (slot_match) begin
                        n_res_status = hmqpt_pkg::ST_HIT;
                        n_res_ppa    = rd_data.ppa;
                        n_res_print  = rd_data.print;
                        n_state      = S_RESULT;
                    end else if (slot_empty || !lookup_more) begin
                        n_res_status = hmqpt_pkg::ST_MISS;
                        n_state      = S_RESULT;
                    end else begin
                        rd_en  = 1'b1;
                        n_idx  = next_idx;
                        n_step = r_step + 8'd1;
                    end
                end else begin
                    if (slot_empty) begin
                        wr_en        = 1'b1;
                        n_res_status = hmqpt_pkg::ST_INSERTED;
                        n_state      = S_RESULT;
                    end else if (promote_more) begin
                        rd_en  = 1'b1;
                        n_idx  = next_idx;
                        n_step = r_step + 8'd1;
                    end else begin
                        wr_en        = 1'b1;
                        wr_addr      = r_addr[hmqpt_pkg::IDX_W-1:0];
                        n_res_status = hmqpt_pkg::ST_OVERWROTE;
                        n_state      = S_RESULT;
                    end
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_CLEAR;
            r_clr_idx       <= '0;
            r_clr_reply     <= 1'b0;
            r_out_valid     <= 1'b0;
            r_hot_threshold <= 8'd2;
            r_max_probes    <= 8'd80;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_clr_reply <= n_clr_reply;
            if (r_state == S_RESULT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    hmqpt_pkg::CFG_HOT_THRESHOLD: r_hot_threshold <= i_cfg_data;
                    hmqpt_pkg::CFG_MAX_PROBES:    r_max_probes    <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_func       <= n_func;
        r_addr       <= n_addr;
        r_ppa        <= n_ppa;
        r_print      <= n_print;
        r_idx        <= n_idx;
        r_step       <= n_step;
        r_res_status <= n_res_status;
        r_res_ppa    <= n_res_ppa;
        r_res_print  <= n_res_print;
        if (r_state == S_RESULT && out_free) begin
            r_out_status <= r_res_status;
            r_out_ppa    <= r_res_ppa;
            r_out_print  <= r_res_print;
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_found_ppa   = r_out_ppa;
    assign o_found_print = r_out_print;

`ifndef NO_ASSERTIONS
    // A lookup never probes past its limit.
    a_lookup_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE && r_func == hmqpt_pkg::FUNC_LOOKUP)
        |-> ({1'b0, r_step} < {1'b0, r_max_probes}))
        else $error("lookup probe step reached the probe limit");

    // Only a lookup can produce a hit.
    a_hit_is_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESULT && r_res_status == hmqpt_pkg::ST_HIT)
        |-> (r_func == hmqpt_pkg::FUNC_LOOKUP))
        else $error("hit reported for a request that is not a lookup");

    // Non-hit results carry zero data.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESULT && r_res_status != hmqpt_pkg::ST_HIT)
        |-> (r_res_ppa == 32'd0 && r_res_print == 32'd0))
        else $error("non-hit result carries data");

    // The table is written only while clearing or while finishing a promote.
    a_write_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_state == S_CLEAR
                   || (r_state == S_PROBE && r_func == hmqpt_pkg::FUNC_PROMOTE)))
        else $error("table written outside clear or promote");

    // The clearing pass after reset returns to idle without a result.
    a_reset_clear_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR && !r_clr_reply
         && r_clr_idx == hmqpt_pkg::t_idx'(hmqpt_pkg::TABLE_ENTRIES - 1))
        |=> (r_state == S_IDLE))
        else $error("reset clearing pass did not end in idle");
`endif

endmodule

### tb/hmqpt_table_monitor.sv
`timescale 1ns / 1ps

module hmqpt_table_monitor
    import hmqpt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_func,
    input  logic [31:0] i_logical_addr,
    input  logic [31:0] i_mapped_ppa,
    input  logic [31:0] i_key_print,
    input  logic [7:0]  i_hit_count,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [2:0]  i_status,
    input  logic [31:0] i_found_ppa,
    input  logic [31:0] i_found_print,
    output int          o_fail_count,
    output int          o_outstanding
);

    localparam logic [7:0] RESET_THRESHOLD = 8'd2;
    localparam logic [7:0] RESET_PROBES    = 8'd80;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] ppa;
        logic [31:0] print;
    } t_reply;

    logic [31:0] shadow_key   [TABLE_ENTRIES];
    logic [31:0] shadow_ppa   [TABLE_ENTRIES];
    logic [31:0] shadow_print [TABLE_ENTRIES];
    logic [7:0]  shadow_threshold;
    logic [7:0]  shadow_probes;
    t_reply      expected_replies [$];
    int          fails = 0;

    initial begin
        o_fail_count  = 0;
        o_outstanding = 0;
    end

    function automatic void empty_shadow_table();
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            shadow_key[i]   = EMPTY_KEY;
            shadow_ppa[i]   = INVALID_PPA;
            shadow_print[i] = '0;
        end
    endfunction

    // Walks the shadow table the way the block does and returns the reply
    // it owes for this request.
    function automatic t_reply apply_request(input logic [1:0] func,
                                             input logic [31:0] addr,
                                             input logic [31:0] ppa,
                                             input logic [31:0] print,
                                             input logic [7:0] hits);
        t_reply      r;
        t_idx        home;
        t_idx        idx;
        logic [31:0] step;
        logic [31:0] sq;
        bit          done;
        r.status = ST_NOT_ELIGIBLE;
        r.ppa    = '0;
        r.print  = '0;
        home     = addr[IDX_W-1:0];
        idx      = home;
        done     = 1'b0;
        case (func)
            FUNC_LOOKUP: begin
                r.status = ST_MISS;
                if (addr != EMPTY_KEY) begin
                    for (step = 1; step < shadow_probes && !done; step++) begin
                        if (shadow_key[idx] == addr) begin
                            r.status = ST_HIT;
                            r.ppa    = shadow_ppa[idx];
                            r.print  = shadow_print[idx];
                            done     = 1'b1;
                        end else if (shadow_key[idx] == EMPTY_KEY) begin
                            done = 1'b1;
                        end else begin
                            sq  = step * step;
                            idx = idx + sq[IDX_W-1:0];
                        end
                    end
                end
            end
            FUNC_PROMOTE: begin
                if (addr != EMPTY_KEY && ppa != INVALID_PPA && hits >= shadow_threshold) begin
                    step = 1;
                    while (shadow_key[idx] != EMPTY_KEY && step < shadow_probes) begin
                        sq   = step * step;
                        idx  = idx + sq[IDX_W-1:0];
                        step = step + 1;
                    end
                    if (shadow_key[idx] == EMPTY_KEY) begin
                        r.status = ST_INSERTED;
                    end else begin
                        // Whole probe window is full, so the home slot is taken over.
                        r.status = ST_OVERWROTE;
                        idx      = home;
                    end
                    shadow_key[idx]   = addr;
                    shadow_ppa[idx]   = ppa;
                    shadow_print[idx] = print;
                end
            end
            FUNC_CLEAR: begin
                empty_shadow_table();
                r.status = ST_CLEARED;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_reply want;
        if (!i_rst_n) begin
            empty_shadow_table();
            shadow_threshold = RESET_THRESHOLD;
            shadow_probes    = RESET_PROBES;
            expected_replies.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_HOT_THRESHOLD) begin
                    shadow_threshold = i_cfg_data;
                end else begin
                    shadow_probes = i_cfg_data;
                end
            end
            // Results are retired before the new request is predicted, so a
            // reply can never be matched against its own request.
            if (i_out_valid && !i_out_stall) begin
                if (expected_replies.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual status %0d",
                             $time, i_status);
                    fails++;
                end else begin
                    want = expected_replies.pop_front();
                    check_field("status", 32'(want.status), 32'(i_status));
                    check_field("found_ppa", want.ppa, i_found_ppa);
                    check_field("found_print", want.print, i_found_print);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_replies.push_back(apply_request(i_func, i_logical_addr,
                                                         i_mapped_ppa, i_key_print,
                                                         i_hit_count));
            end
        end
        o_outstanding <= expected_replies.size();
        o_fail_count  <= fails;
    end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import hmqpt_pkg::*;

    localparam logic [1:0] FUNC_RESERVED   = 2'd3;
    localparam int         RANDOM_REQUESTS = 1300;
    localparam int         PHASE_LEN       = 260;
    localparam int         QUIET_LIMIT     = 20000;
    localparam int         TAIL_CYCLES     = 300;
    localparam int         KEY_POOL_DEPTH  = 48;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_cfg_we       = 1'b0;
    logic        i_cfg_index    = 1'b0;
    logic [7:0]  i_cfg_data     = '0;
    logic        i_in_valid     = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_func         = '0;
    logic [31:0] i_logical_addr = '0;
    logic [31:0] i_mapped_ppa   = '0;
    logic [31:0] i_key_print    = '0;
    logic [7:0]  i_hit_count    = '0;
    logic        o_out_valid;
    logic        i_out_stall    = 1'b0;
    logic [2:0]  o_status;
    logic [31:0] o_found_ppa;
    logic [31:0] o_found_print;

    int          fail_count;
    int          outstanding;
    int          quiet_cycles   = 0;
    int          send_idle_pct  = 26;
    int          recv_idle_pct  = 54;
    logic [7:0]  cur_threshold  = 8'd2;
    t_idx        hot_base       = '0;
    logic [31:0] promoted_keys [$];

    hot_mapping_quadratic_probe_table_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_logical_addr (i_logical_addr),
        .i_mapped_ppa   (i_mapped_ppa),
        .i_key_print    (i_key_print),
        .i_hit_count    (i_hit_count),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_found_ppa    (o_found_ppa),
        .o_found_print  (o_found_print)
    );

    hmqpt_table_monitor u_table_monitor (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_logical_addr (i_logical_addr),
        .i_mapped_ppa   (i_mapped_ppa),
        .i_key_print    (i_key_print),
        .i_hit_count    (i_hit_count),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_status       (o_status),
        .i_found_ppa    (o_found_ppa),
        .i_found_print  (o_found_print),
        .o_fail_count   (fail_count),
        .o_outstanding  (outstanding)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Any cycle that moves a request or a result restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_request(input logic [1:0] func, input logic [31:0] addr,
                                input logic [31:0] ppa, input logic [31:0] print,
                                input logic [7:0] hits);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid     <= 1'b1;
        i_func         <= func;
        i_logical_addr <= addr;
        i_mapped_ppa   <= ppa;
        i_key_print    <= print;
        i_hit_count    <= hits;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // The first edge lets the monitor count a request taken on the current one.
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic index, input logic [7:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    task automatic reconfigure(input logic [7:0] threshold, input logic [7:0] probes);
        wait_for_drain();
        write_reg(CFG_HOT_THRESHOLD, threshold);
        write_reg(CFG_MAX_PROBES, probes);
        i_cfg_we      <= 1'b0;
        cur_threshold  = threshold;
        hot_base       = t_idx'($urandom_range(TABLE_ENTRIES - 1));
    endtask

    // Most keys land on a few neighboring home slots so that probe chains
    // grow long and run into each other.
    function automatic logic [31:0] pick_key(input bit reuse);
        logic [31:0] k;
        if (reuse && promoted_keys.size() != 0 && $urandom_range(99) < 70) begin
            return promoted_keys[$urandom_range(promoted_keys.size() - 1)];
        end
        k = $urandom();
        if ($urandom_range(99) < 80) begin
            k[IDX_W-1:0] = hot_base + t_idx'($urandom_range(15));
        end
        if (k == EMPTY_KEY) begin
            k = 32'hFFFF_FFFE;
        end
        return k;
    endfunction

    function automatic logic [7:0] pick_hits();
        int t;
        if ($urandom_range(1) == 1) begin
            return 8'($urandom_range(255));
        end
        t = int'(cur_threshold) + int'($urandom_range(2)) - 1;
        if (t < 0) begin
            t = 0;
        end else if (t > 255) begin
            t = 255;
        end
        return 8'(t);
    endfunction

    initial begin : stimulus
        int          n;
        int          sel;
        logic [31:0] addr;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, under the reset settings.
        send_request(FUNC_LOOKUP, 32'd0, 32'd0, 32'd0, 8'd0);
        send_request(FUNC_PROMOTE, 32'd0, 32'd0, 32'd0, 8'd2);
        send_request(FUNC_LOOKUP, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
        send_request(FUNC_PROMOTE, 32'd4096, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 8'hFF);
        send_request(FUNC_LOOKUP, 32'd4096, 32'd0, 32'd0, 8'd0);
        send_request(FUNC_PROMOTE, 32'hFFFF_FFFE, 32'h1234_5678, 32'h8765_4321, 8'd2);
        send_request(FUNC_LOOKUP, 32'hFFFF_FFFE, 32'd0, 32'd0, 8'd0);
        // The reserved key is neither stored nor ever found.
        send_request(FUNC_PROMOTE, EMPTY_KEY, 32'd7, 32'd7, 8'hFF);
        send_request(FUNC_LOOKUP, EMPTY_KEY, 32'd0, 32'd0, 8'd0);
        send_request(FUNC_PROMOTE, 32'd77, INVALID_PPA, 32'd1, 8'hFF);
        send_request(FUNC_PROMOTE, 32'd78, 32'd5, 32'd1, 8'd1);
        send_request(FUNC_RESERVED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
        send_request(FUNC_RESERVED, 32'd0, 32'd0, 32'd0, 8'd0);
        send_request(FUNC_LOOKUP, 32'd8192, 32'd0, 32'd0, 8'd0);
        // A second copy of an existing key goes further down the chain.
        send_request(FUNC_PROMOTE, 32'd0, 32'hAAAA_5555, 32'h5555_AAAA, 8'd3);
        send_request(FUNC_LOOKUP, 32'd0, 32'd0, 32'd0, 8'd0);
        send_request(FUNC_CLEAR, 32'd0, 32'd0, 32'd0, 8'd0);
        send_request(FUNC_LOOKUP, 32'd0, 32'd0, 32'd0, 8'd0);
        send_request(FUNC_LOOKUP, 32'hFFFF_FFFE, 32'd0, 32'd0, 8'd0);

        for (n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n % PHASE_LEN == 0) begin
                case (n / PHASE_LEN)
                    0: reconfigure(8'd0, 8'd2);
                    1: reconfigure(8'd0, 8'd255);
                    2: reconfigure(8'd255, 8'd17);
                    3: reconfigure(8'($urandom_range(255)), 8'($urandom_range(255, 2)));
                    default: reconfigure(8'd1, 8'd80);
                endcase
            end
            if (n == RANDOM_REQUESTS / 3) begin
                send_idle_pct = 54;
                recv_idle_pct = 26;
            end else if (n == 2 * RANDOM_REQUESTS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            sel = $urandom_range(99);
            if (sel < 45) begin
                addr = pick_key(sel < 7);
                send_request(FUNC_PROMOTE, addr,
                             ($urandom_range(99) < 5) ? INVALID_PPA : 32'($urandom()),
                             $urandom(), pick_hits());
                promoted_keys.push_back(addr);
                if (promoted_keys.size() > KEY_POOL_DEPTH) begin
                    void'(promoted_keys.pop_front());
                end
            end else if (sel < 88) begin
                send_request(FUNC_LOOKUP, pick_key(1'b1), $urandom(), $urandom(),
                             8'($urandom_range(255)));
            end else if (sel < 91) begin
                send_request(FUNC_RESERVED, $urandom(), $urandom(), $urandom(),
                             8'($urandom_range(255)));
            end else if (sel < 92) begin
                send_request(FUNC_CLEAR, $urandom(), $urandom(), $urandom(),
                             8'($urandom_range(255)));
                promoted_keys.delete();
            end else if (sel < 96) begin
                send_request($urandom_range(1) ? FUNC_PROMOTE : FUNC_LOOKUP, EMPTY_KEY,
                             $urandom(), $urandom(), 8'hFF);
            end else begin
                send_request(FUNC_PROMOTE, $urandom(), $urandom(), $urandom(),
                             8'($urandom_range(255)));
            end
        end

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
